// File: rtl/hash_set_id_table_top_defines.svh
// ----------------------------------------------------------------------------
// hash set id table: assertion macros
// Shared assertion forms for the table RTL.
// ----------------------------------------------------------------------------
`ifndef HASH_SET_ID_TABLE_TOP_DEFINES_SVH
`define HASH_SET_ID_TABLE_TOP_DEFINES_SVH

// property a must imply b at the same edge
`define HST_ASSERT_IMPL(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed");

// property a must imply b at the next edge
`define HST_ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");

`endif

// File: rtl/hst_pkg.sv
// ----------------------------------------------------------------------------
// hst_pkg
// Types and constants of the hash set id table.
// ----------------------------------------------------------------------------
`default_nettype none
package hst_pkg;
   localparam int ID_W    = 64;
   localparam int OP_W    = 2;
   localparam int SLOT_W  = 8;
   localparam int CNT_W   = 7;

   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_FIND   = 2'd1,
      OP_REMOVE = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_READ,
      ST_SCAN,
      ST_WRITE,
      ST_DONE
   } state_type;

   localparam logic [0:0] CSR_BUCKET_COUNT = 1'b0;
endpackage
`default_nettype wire

// File: rtl/hst_if.sv
// ----------------------------------------------------------------------------
// hst_req_if / hst_rsp_if
// Valid-ready channels of the table.
// ----------------------------------------------------------------------------
`default_nettype none
interface hst_req_if;
   logic                      valid;
   logic                      ready;
   logic [1:0]                op;
   logic [63:0]               entry_id;
   modport source (output valid, op, entry_id, input ready);
   modport sink   (input valid, op, entry_id, output ready);
endinterface

interface hst_rsp_if;
   logic       valid;
   logic       ready;
   logic       hit;
   logic       bucket_full;
   logic [7:0] slot_index;
   modport source (output valid, hit, bucket_full, slot_index, input ready);
   modport sink   (input valid, hit, bucket_full, slot_index, output ready);
endinterface
`default_nettype wire

// File: rtl/hst_divider.sv
// ----------------------------------------------------------------------------
// hst_divider
// Restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module hst_divider #(
   parameter int REM_W = 7
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [63:0]       dividend,
   input  wire logic [REM_W-1:0]  divisor,
   output logic                   done,
   output logic [REM_W-1:0]       remainder
);
   import hst_pkg::*;

   logic [63:0]      shift_ff, shift_in;
   logic [REM_W:0]   rem_ff, rem_in;
   logic [6:0]       cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic [REM_W:0]   trial;

   always_comb begin
      shift_in = shift_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      trial    = {rem_ff[REM_W-1:0], shift_ff[63]};
      if (start) begin
         shift_in = dividend;
         rem_in   = '0;
         cnt_in   = 7'd0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         shift_in = {shift_ff[62:0], 1'b0};
         if (trial >= {1'b0, divisor}) rem_in = trial - {1'b0, divisor};
         else rem_in = trial;
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'd63) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      cnt_ff   <= cnt_in;
      if (reset) busy_ff <= 1'b0;
      else busy_ff <= busy_in;
   end

   assign done      = busy_ff && (cnt_ff == 7'd63) && !start;
   assign remainder = rem_in[REM_W-1:0];
endmodule
`default_nettype wire

// File: rtl/hst_store.sv
// ----------------------------------------------------------------------------
// hst_store
// Bucket memory: one row of WAYS ids, valid bits per row in flops.
// ----------------------------------------------------------------------------
`default_nettype none
module hst_store #(
   parameter int ROWS   = 64,
   parameter int WAYS   = 4,
   parameter int ROW_W  = 6
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic [ROW_W-1:0]       rd_addr,
   output logic [WAYS-1:0][63:0]       rd_ids,
   output logic [WAYS-1:0]             rd_valid,
   input  wire logic                   wr_en,
   input  wire logic [ROW_W-1:0]       wr_addr,
   input  wire logic [WAYS-1:0][63:0]  wr_ids,
   input  wire logic [WAYS-1:0]        wr_valid
);
   import hst_pkg::*;

   logic [WAYS-1:0][63:0] mem [ROWS];
   logic [ROWS-1:0][WAYS-1:0] valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_ids;
      rd_ids <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= '0;
      else if (wr_en) valid_ff[wr_addr] <= wr_valid;
      rd_valid <= reset ? '0 : valid_ff[rd_addr];
   end
endmodule
`default_nettype wire

// File: rtl/hash_set_id_table_top.sv
// ----------------------------------------------------------------------------
// hash_set_id_table_top
// Bucketed membership table of 64-bit ids with add, find and remove.
// ----------------------------------------------------------------------------
// One transaction at a time: the bucket is id mod bucket_count, found by a
// restoring remainder unit, followed by a bucket row read, a compare of all
// ways, a write-back and a step to load the output register. Valid bits are
// flip-flops cleared at reset, so there is no clearing pass. A new request is
// taken only once the previous result has left the output register, so a
// result side that holds rsp.ready low also holds off the next request.
`default_nettype none
`include "hash_set_id_table_top_defines.svh"
module hash_set_id_table_top #(
   parameter int BUCKETS = 64,
   parameter int WAYS    = 4
) (
   input  wire logic         clock,
   input  wire logic         reset,
   hst_req_if.sink           req,
   hst_rsp_if.source         rsp,
   input  wire logic         csr_psel,
   input  wire logic         csr_penable,
   input  wire logic         csr_pwrite,
   input  wire logic [1:0]   csr_paddr,
   input  wire logic [31:0]  csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);
   import hst_pkg::*;

   localparam int ROW_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int REM_W  = $clog2(BUCKETS + 1);
   localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int SLOT_FW = ROW_W + WAY_W + 8;

   // ---- configuration register
   logic [CNT_W-1:0] bcount_ff;
   logic             csr_wr;
   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite;
   always_ff @(posedge clock) begin
      if (reset) bcount_ff <= CNT_W'(64);
      else if (csr_wr && csr_paddr == {CSR_BUCKET_COUNT, 1'b0}) bcount_ff <= csr_pwdata[6:0];
   end
   assign csr_prdata = (csr_paddr == {CSR_BUCKET_COUNT, 1'b0}) ? {25'd0, bcount_ff} : 32'd0;

   // effective divisor: 0 acts as 1, above BUCKETS clamps
   logic [REM_W-1:0] divisor;
   always_comb begin
      if (bcount_ff == '0) divisor = REM_W'(1);
      else if (32'(bcount_ff) > BUCKETS) divisor = REM_W'(BUCKETS);
      else divisor = REM_W'(bcount_ff);
   end

   // ---- control
   state_type state_ff, state_in;
   logic [1:0]  op_ff;
   logic [63:0] id_ff;
   logic [ROW_W-1:0] row_ff;
   logic div_done;
   logic [REM_W-1:0] rem;
   logic req_acc;
   logic out_valid_ff, out_hit_ff, out_full_ff;
   logic [7:0] out_slot_ff;

   assign req.ready = (state_ff == ST_IDLE) && !out_valid_ff;
   assign req_acc   = req.valid && req.ready;

   hst_divider #(.REM_W(REM_W)) u_div (
      .clock, .reset, .start(req_acc), .dividend(req.entry_id), .divisor,
      .done(div_done), .remainder(rem)
   );

   logic [WAYS-1:0][63:0] rd_ids, wr_ids_ff;
   logic [WAYS-1:0]       rd_valid, wr_valid_ff;
   logic                  wr_en;

   hst_store #(.ROWS(BUCKETS), .WAYS(WAYS), .ROW_W(ROW_W)) u_store (
      .clock, .reset, .rd_addr(row_ff), .rd_ids, .rd_valid,
      .wr_en, .wr_addr(row_ff), .wr_ids(wr_ids_ff), .wr_valid(wr_valid_ff)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_acc) state_in = ST_DIV;
         ST_DIV:   if (div_done) state_in = ST_READ;
         ST_READ:  state_in = ST_SCAN;
         ST_SCAN:  state_in = ST_WRITE;
         ST_WRITE: state_in = ST_DONE;
         ST_DONE:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   assign wr_en = (state_ff == ST_WRITE);

   // match and free-way search over the row
   logic            found, has_free;
   logic [WAY_W-1:0] fway, eway;
   always_comb begin
      found = 1'b0; has_free = 1'b0; fway = '0; eway = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (rd_valid[w] && rd_ids[w] == id_ff) begin
            found = 1'b1; fway = WAY_W'(w);
         end
         if (!rd_valid[w]) begin
            has_free = 1'b1; eway = WAY_W'(w);
         end
      end
   end

   logic [SLOT_FW-1:0] base;
   assign base = SLOT_FW'(row_ff) * SLOT_FW'(WAYS);

   always_ff @(posedge clock) begin
      if (req_acc) begin
         op_ff <= req.op;
         id_ff <= req.entry_id;
      end
      if (state_ff == ST_DIV && div_done) row_ff <= ROW_W'(rem);
      if (state_ff == ST_SCAN) begin
         wr_ids_ff   <= rd_ids;
         wr_valid_ff <= rd_valid;
         out_hit_ff  <= 1'b0;
         out_full_ff <= 1'b0;
         out_slot_ff <= 8'd0;
         case (op_type'(op_ff))
            OP_ADD: if (!found) begin
               if (has_free) begin
                  wr_ids_ff[eway]   <= id_ff;
                  wr_valid_ff[eway] <= 1'b1;
                  out_hit_ff  <= 1'b1;
                  out_slot_ff <= 8'(base + SLOT_FW'(eway));
               end else out_full_ff <= 1'b1;
            end
            OP_FIND: if (found) begin
               out_hit_ff  <= 1'b1;
               out_slot_ff <= 8'(base + SLOT_FW'(fway));
            end
            OP_REMOVE: if (found) begin
               wr_valid_ff[fway] <= 1'b0;
               out_hit_ff  <= 1'b1;
               out_slot_ff <= 8'(base + SLOT_FW'(fway));
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_DONE) out_valid_ff <= 1'b1;
         else if (rsp.ready) out_valid_ff <= 1'b0;
      end
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.hit         = out_hit_ff;
   assign rsp.bucket_full = out_full_ff;
   assign rsp.slot_index  = out_slot_ff;

   `HST_ASSERT_IMPL(a_ready_idle, clock, reset, req.ready, state_ff == ST_IDLE)
   `HST_ASSERT_IMPL(a_hit_full, clock, reset, rsp.valid, !(rsp.hit && rsp.bucket_full))
   `HST_ASSERT_IMPL(a_miss_slot, clock, reset, rsp.valid && !rsp.hit, rsp.slot_index == 8'd0)
   `HST_ASSERT_NEXT(a_acc_div, clock, reset, req_acc, state_ff == ST_DIV)
endmodule
`default_nettype wire

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// tb: hash set id table testbench
// Directed table of transactions, then random add/find/remove traffic against
// a behavioral table model; results are checked in order, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module tb;
   import hst_pkg::*;

   localparam int NBUCK = 64;
   localparam int NWAYS = 4;
   localparam int NSLOT = NBUCK * NWAYS;
   localparam int LIMIT = 2000000;

   typedef struct packed {
      logic       hit;
      logic       full;
      logic [7:0] slot;
   } lookup_res_type;

   typedef struct {
      op_type         op;
      logic [63:0]    id;
      bit             typed;   // expected value written in the row
      lookup_res_type res;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic       csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   hst_req_if req ();
   hst_rsp_if rsp ();

   hash_set_id_table_top dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata), .csr_pready(csr_pready)
   );

   always #10 clock = ~clock;

   // model state
   logic [63:0] tbl_ids [NSLOT];
   bit          tbl_used [NSLOT];
   logic [6:0]  tbl_count;
   lookup_res_type pending_res [$];
   int  n_errors = 0;
   int  cycles = 0;
   bit  calm = 1'b0;   // no idling while set

   // pool of ids so find/remove hit often
   logic [63:0] id_pool [$];

   function automatic lookup_res_type table_apply(op_type op, logic [63:0] id);
      lookup_res_type r;
      int nb, base, w, f;
      r = '0;
      nb = (tbl_count == 0) ? 1 : (tbl_count > NBUCK ? NBUCK : int'(tbl_count));
      base = int'(id % 64'(nb)) * NWAYS;
      w = -1;
      for (int i = 0; i < NWAYS; i++)
         if (w < 0 && tbl_used[base+i] && tbl_ids[base+i] == id) w = i;
      case (op)
         OP_ADD: if (w < 0) begin
            f = -1;
            for (int i = 0; i < NWAYS; i++)
               if (f < 0 && !tbl_used[base+i]) f = i;
            if (f >= 0) begin
               tbl_used[base+f] = 1'b1;
               tbl_ids[base+f] = id;
               r.hit = 1'b1;
               r.slot = 8'(base + f);
            end else r.full = 1'b1;
         end
         OP_FIND: if (w >= 0) begin
            r.hit = 1'b1;
            r.slot = 8'(base + w);
         end
         OP_REMOVE: if (w >= 0) begin
            tbl_used[base+w] = 1'b0;
            r.hit = 1'b1;
            r.slot = 8'(base + w);
         end
         default: ;
      endcase
      return r;
   endfunction

   // cycle counter / timeout
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // result side: random stalls, in-order compare
   initial begin
      rsp.ready = 1'b0;
   end
   always @(posedge clock) begin
      lookup_res_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (pending_res.size() == 0) begin
            $display("%0t: unexpected transaction hit=%b full=%b slot=%0d", $time,
                     rsp.hit, rsp.bucket_full, rsp.slot_index);
            n_errors++;
         end else begin
            want = pending_res.pop_front();
            if (want.hit !== rsp.hit) begin
               $display("%0t: hit exp %b got %b", $time, want.hit, rsp.hit);
               n_errors++;
            end
            if (want.full !== rsp.bucket_full) begin
               $display("%0t: bucket_full exp %b got %b", $time, want.full,
                        rsp.bucket_full);
               n_errors++;
            end
            if (want.slot !== rsp.slot_index) begin
               $display("%0t: slot_index exp %0d got %0d", $time, want.slot,
                        rsp.slot_index);
               n_errors++;
            end
         end
      end
      rsp.ready <= calm ? 1'b1 : ($urandom_range(99) >= 6);
   end

   // APB write: setup then access
   task automatic write_count(logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_penable <= 1'b0;
      csr_paddr <= 2'(CSR_BUCKET_COUNT) << 2; csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      tbl_count = value[6:0];
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      while (pending_res.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   // one transaction; check against row value if typed
   // returns at the accepting edge with valid still high
   task automatic send_req(op_type op, logic [63:0] id, bit typed, lookup_res_type res);
      lookup_res_type pred;
      while (!calm && $urandom_range(99) < 6) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      pred = table_apply(op, id);
      if (typed && pred !== res) begin
         $display("%0t: table row exp %h model %h", $time, res, pred);
         n_errors++;
      end
      pending_res.push_back(pred);
      req.valid <= 1'b1; req.op <= op; req.entry_id <= id;
      // ready only changes on clock edges: sample it mid-cycle
      @(negedge clock);
      while (!req.ready) @(negedge clock);
      @(posedge clock);
   endtask

   stim_row_type rows [$];
   task automatic row(op_type op, logic [63:0] id, bit typed = 0,
                      logic h = 0, logic f = 0, logic [7:0] s = 0);
      stim_row_type r;
      r.op = op; r.id = id; r.typed = typed; r.res = '{h, f, s};
      rows.push_back(r);
   endtask

   initial begin
      logic [63:0] id;
      int pick, counts [6];
      op_type op;
      req.valid = 1'b0; req.op = OP_ADD; req.entry_id = '0;
      tbl_count = 7'd64;
      foreach (tbl_used[i]) tbl_used[i] = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: after reset, extremes, duplicates, full bucket, unused op
      row(OP_FIND, 64'd0, 1, 0, 0, 0);
      row(OP_ADD, 64'd0, 1, 1, 0, 0);
      row(OP_ADD, 64'd0, 1, 0, 0, 0);          // duplicate
      row(OP_ADD, 64'd64, 1, 1, 0, 1);
      row(OP_ADD, 64'd128, 1, 1, 0, 2);
      row(OP_ADD, 64'd192, 1, 1, 0, 3);
      row(OP_ADD, 64'd256, 1, 0, 1, 0);        // bucket full
      row(OP_FIND, 64'd128, 1, 1, 0, 2);
      row(OP_REMOVE, 64'd64, 1, 1, 0, 1);
      row(OP_REMOVE, 64'd64, 1, 0, 0, 0);
      row(OP_ADD, 64'd256, 1, 1, 0, 1);        // lowest free way
      row(OP_ADD, '1, 1, 1, 0, 252);           // max id -> bucket 63
      row(OP_FIND, '1, 1, 1, 0, 252);
      row(OP_NONE, '1, 1, 0, 0, 0);
      row(OP_FIND, 64'h5555_5555_5555_5555);
      row(OP_ADD, 64'hAAAA_AAAA_AAAA_AAAA);
      row(OP_REMOVE, 64'hAAAA_AAAA_AAAA_AAAA);
      row(OP_REMOVE, '1);
      foreach (rows[i]) send_req(rows[i].op, rows[i].id, rows[i].typed, rows[i].res);
      drain();

      // zero acts as one, oversized acts as max; stale entries remain
      write_count(32'd0);
      send_req(OP_FIND, 64'd128, 0, '0);
      send_req(OP_ADD, 64'd77, 0, '0);
      send_req(OP_ADD, 64'hFFFF_0000_1234_5678, 0, '0);
      drain();
      write_count(32'd127);
      send_req(OP_FIND, 64'd128, 0, '0);
      send_req(OP_FIND, 64'd77, 0, '0);
      drain();

      // random phases over several bucket counts
      counts = '{1, 3, 64, 17, 100, 2};
      foreach (counts[k]) begin
         write_count(32'(counts[k]) | ($urandom() & 32'hFFFF_FF80));
         calm = (k == 2);
         repeat (290) begin
            pick = $urandom_range(99);
            if (pick < 10 || id_pool.size() == 0)
               id = {$urandom(), $urandom()};
            else begin
               id = id_pool[$urandom_range(id_pool.size() - 1)];
               if (pick < 16) id = id + 64'(NBUCK * $urandom_range(3));
            end
            if (id_pool.size() < 40) id_pool.push_back(id);
            else id_pool[$urandom_range(39)] = id;
            pick = $urandom_range(99);
            op = pick < 40 ? OP_ADD : pick < 70 ? OP_FIND : pick < 97 ? OP_REMOVE
                 : OP_NONE;
            send_req(op, id, 0, '0);
         end
         drain();
      end
      calm = 1'b0;

      if (n_errors == 0 && pending_res.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule

// File: sim.f
+incdir+rtl
rtl/hst_pkg.sv
rtl/hst_if.sv
rtl/hst_divider.sv
rtl/hst_store.sv
rtl/hash_set_id_table_top.sv
bench/tb.sv
